### hw/rtl/isp_pkg.sv
// isp_pkg: shared types, widths and constants for the inertial scroll block.
// No dependencies; imported by isp_mul, isp_div and inertial_scroll_physics.
package isp_pkg;

    localparam int VALUE_WIDTH_DEF    = 28;
    localparam int TIME_FRAC_BITS_DEF = 16;
    localparam int EXP_TABLE_SIZE_DEF = 256;

    localparam int ELAPSED_W = 16;
    localparam int GAIN_W    = 16;

    // shared multiplier: 63-bit magnitude times 32-bit operand, 16-bit digit per cycle
    localparam int MUL_A_W     = 63;
    localparam int MUL_B_W     = 32;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_DIGIT_W = 16;
    localparam int MUL_DIGITS  = (MUL_A_W + MUL_DIGIT_W - 1) / MUL_DIGIT_W;

    // intermediates saturate at +-2^62
    localparam int WIDE_W  = 66;
    localparam int LIM_EXP = 62;

    localparam int ONE_PX     = 256;
    localparam int HALF_PX    = 128;
    localparam int REL_LIMIT  = 1024000;
    localparam int OVER_LIMIT = 15360;
    localparam int BOUNCE_Q16 = 19661;
    localparam int DRAG_SCALE = 10000;
    localparam int Y_FRAC     = 46;
    localparam int N_W        = 17;
    localparam int EXP_W      = 31;
    localparam int EXP_SH_MAX = 31;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [30:0] LN2_Q30   = 31'd744261118;

    localparam logic [GAIN_W-1:0] DECAY_RST = 16'd1024;
    localparam logic [GAIN_W-1:0] STIFF_RST = 16'd35840;
    localparam logic [GAIN_W-1:0] DAMP_RST  = 16'd5120;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_DRAG    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_RESTART = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_MIN   = 3'd0,
        REG_MAX   = 3'd1,
        REG_DECAY = 3'd2,
        REG_STIFF = 3'd3,
        REG_DAMP  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } t_mul_rsp;

endpackage

### hw/rtl/inertial_scroll_physics.sv
// inertial_scroll_physics: kinetic scroller with spring overscroll, top level.
// Depends on isp_pkg, isp_mul (shared multiplier) and isp_div (drag divider).
//
//  channel | direction | handshake               | payload
//  input   | in        | i_in_valid / o_in_ready | i_command, i_delta, i_elapsed
//  output  | out       | o_out_valid/i_out_ready | o_position, o_velocity, o_dragging, o_resting
//  config  | in        | APB psel/penable/pready | paddr, pwdata, prdata
//
// Restart and release pass through S_FIN to the result register; a drag with velocity runs
// the divider, one bit a cycle; a tick runs 4 to 6 products through the shared multiplier,
// plus one table lookup on the friction path.
// Synchronous active-low reset clears state, config and the output valid flag, not the result data.
// A transfer on the input is taken only in idle; a finished result waits in its register
// while the next item is worked on.
module inertial_scroll_physics #(
    parameter int VALUE_WIDTH    = isp_pkg::VALUE_WIDTH_DEF,
    parameter int TIME_FRAC_BITS = isp_pkg::TIME_FRAC_BITS_DEF,
    parameter int EXP_TABLE_SIZE = isp_pkg::EXP_TABLE_SIZE_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_in_valid,
    output logic                                          o_in_ready,
    input  logic [1:0]                                    i_command,
    input  logic signed [VALUE_WIDTH-1:0]                 i_delta,
    input  logic [isp_pkg::ELAPSED_W-1:0]                 i_elapsed,
    output logic                                          o_out_valid,
    input  logic                                          i_out_ready,
    output logic signed [VALUE_WIDTH-1:0]                 o_position,
    output logic signed [VALUE_WIDTH-1:0]                 o_velocity,
    output logic                                          o_dragging,
    output logic                                          o_resting,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [((VALUE_WIDTH > 32) ? 3 : 2)+2:0]       paddr,
    input  logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0]     pwdata,
    output logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0]     prdata,
    output logic                                          pready
);
    import isp_pkg::*;

    localparam int W      = VALUE_WIDTH;
    localparam int TFB    = TIME_FRAC_BITS;
    localparam int QW     = W + TFB;
    localparam int DATA_W = (W > 32) ? 64 : 32;
    localparam int ASH    = (W > 32) ? 3 : 2;
    localparam int ADDR_W = ASH + 3;
    localparam int IW     = $clog2(EXP_TABLE_SIZE);
    localparam int ES_W   = ELAPSED_W + 14;

    localparam logic signed [WIDE_W-1:0] VMAX    = (WIDE_W'(1) << (W - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] VMIN    = -VMAX - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] LIM     = WIDE_W'(1) << LIM_EXP;
    localparam logic signed [WIDE_W-1:0] ONE_W   = WIDE_W'(ONE_PX);
    localparam logic signed [WIDE_W-1:0] HALF_W  = WIDE_W'(HALF_PX);
    localparam logic signed [WIDE_W-1:0] REL_W   = WIDE_W'(REL_LIMIT);
    localparam logic signed [WIDE_W-1:0] OVER_W  = WIDE_W'(OVER_LIMIT);
    localparam logic [ES_W-1:0]          DRAG_TH = ES_W'(1) << TFB;

    typedef logic [EXP_W-1:0] t_exp_tab [EXP_TABLE_SIZE];

    // 2^(-i/N) in Q1.30 from a Taylor series of exp(-z) up to the 16th power
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab           tab;
        logic [63:0]        z;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
            z    = (64'(i) * 64'(LN2_Q30)) / EXP_TABLE_SIZE;
            term = 64'd1 << 30;
            sum  = $signed(term);
            for (int k = 1; k <= 16; k++) begin
                term = ((term * z) >> 30) / 64'(k);
                if (k % 2 == 1) sum = sum - $signed(term);
                else            sum = sum + $signed(term);
            end
            tab[i] = EXP_W'(sum);
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

    function automatic logic signed [WIDE_W-1:0] ext(input logic signed [W-1:0] x);
        return WIDE_W'(x);
    endfunction

    function automatic logic signed [W-1:0] sat_v(input logic signed [WIDE_W-1:0] x);
        if (x > VMAX)      return W'(VMAX);
        else if (x < VMIN) return W'(VMIN);
        else               return W'(x);
    endfunction

    function automatic logic signed [WIDE_W-1:0] sat_lim(input logic signed [WIDE_W-1:0] x);
        if (x > LIM)       return LIM;
        else if (x < -LIM) return -LIM;
        else               return x;
    endfunction

    function automatic logic signed [WIDE_W-1:0] smul_fin(input logic neg,
                                                         input logic [MUL_P_W-1:0] p);
        logic [MUL_P_W-1:0]        lim_p;
        logic signed [WIDE_W-1:0]  m;
        lim_p = MUL_P_W'(1) << LIM_EXP;
        m = (p > lim_p) ? LIM : $signed(WIDE_W'(p));
        return neg ? -m : m;
    endfunction

    // round half away from zero
    function automatic logic signed [WIDE_W-1:0] rsh_r(input logic signed [WIDE_W-1:0] x,
                                                      input int sh);
        logic [WIDE_W-1:0] m;
        m = (x < 0) ? WIDE_W'(-x) : WIDE_W'(x);
        m = (m + (WIDE_W'(1) << (sh - 1))) >> sh;
        return (x < 0) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [MUL_A_W-1:0] mag_a(input logic signed [WIDE_W-1:0] x);
        return (x < 0) ? MUL_A_W'(-x) : MUL_A_W'(x);
    endfunction

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_DIV  = 13'b0000000000010,
        S_K    = 13'b0000000000100,
        S_C    = 13'b0000000001000,
        S_AD   = 13'b0000000010000,
        S_VD   = 13'b0000000100000,
        S_BNC  = 13'b0000001000000,
        S_X    = 13'b0000010000000,
        S_Y    = 13'b0000100000000,
        S_I    = 13'b0001000000000,
        S_T    = 13'b0010000000000,
        S_E    = 13'b0100000000000,
        S_FIN  = 13'b1000000000000
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_issue, n_issue;
    logic signed [W-1:0]     r_p, n_p;
    logic signed [W-1:0]     r_v, n_v;
    logic                    r_drag, n_drag;
    logic [ELAPSED_W-1:0]    r_e, n_e;
    logic signed [W-1:0]     r_bound, n_bound;
    logic                    r_ob, n_ob;
    logic                    r_hi_done, n_hi_done;
    logic                    r_neg, n_neg;
    logic signed [WIDE_W-1:0] r_acc, n_acc;
    logic [31:0]             r_x, n_x;
    logic [N_W-1:0]          r_n, n_n;
    logic [Y_FRAC-1:0]       r_f, n_f;
    logic [IW-1:0]           r_idx, n_idx;
    logic [EXP_W-1:0]        r_expf;
    logic                    r_out_valid, n_out_valid;
    logic signed [W-1:0]     r_out_pos, r_out_vel;
    logic                    r_out_drag, r_out_rest;
    logic                    load_out;
    logic                    out_rest;

    logic signed [W-1:0]     r_min, r_max;
    logic [GAIN_W-1:0]       r_decay, r_stiff, r_damp;

    t_mul_req                mreq;
    t_mul_rsp                mrsp;
    logic                    mneg;
    logic                    div_start;
    logic                    div_done;
    logic [W-1:0]            div_mag;
    logic [QW-1:0]           div_quot;
    logic [ES_W-1:0]         e_scaled;

    logic                    cfg_wr;
    logic [2:0]              cfg_idx;

    isp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rsp   (mrsp)
    );

    isp_div #(
        .VALUE_WIDTH    (W),
        .TIME_FRAC_BITS (TFB)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_mag     (div_mag),
        .i_divisor (i_elapsed),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign div_mag    = i_delta[W-1] ? W'(-i_delta) : W'(i_delta);
    assign e_scaled   = ES_W'(i_elapsed) * ES_W'(DRAG_SCALE);
    assign out_rest   = !r_drag && ext(r_v) > -HALF_W && ext(r_v) < HALF_W &&
                        r_p >= r_min && r_p <= r_max;

    // operand select for the shared multiplier
    always_comb begin
        logic signed [WIDE_W-1:0] d;
        d        = ext(r_p) - ext(r_bound);
        mreq.start = 1'b0;
        mreq.a   = mag_a(ext(r_v));
        mreq.b   = MUL_B_W'(r_e);
        mneg     = r_v < 0;
        case (r_state)
            S_K: begin
                mreq.start = r_issue;
                mreq.a     = mag_a(d);
                mreq.b     = MUL_B_W'(r_stiff);
                mneg       = d < 0;
            end
            S_C: begin
                mreq.start = r_issue;
                mreq.b     = MUL_B_W'(r_damp);
            end
            S_AD: begin
                mreq.start = r_issue;
                mreq.a     = mag_a(r_acc);
                mneg       = r_acc < 0;
            end
            S_VD: begin
                mreq.start = r_issue;
            end
            S_BNC: begin
                mreq.start = r_issue;
                mreq.b     = MUL_B_W'(BOUNCE_Q16);
            end
            S_X: begin
                mreq.start = r_issue;
                mreq.a     = MUL_A_W'(r_e);
                mreq.b     = MUL_B_W'(r_decay);
                mneg       = 1'b0;
            end
            S_Y: begin
                mreq.start = r_issue;
                mreq.a     = MUL_A_W'(r_x);
                mreq.b     = MUL_B_W'(LOG2E_Q30);
                mneg       = 1'b0;
            end
            S_I: begin
                mreq.start = r_issue;
                mreq.a     = MUL_A_W'(r_f);
                mreq.b     = MUL_B_W'(EXP_TABLE_SIZE);
                mneg       = 1'b0;
            end
            S_E: begin
                mreq.start = r_issue;
                mreq.b     = MUL_B_W'(r_expf);
            end
            default: begin
                mreq.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        logic signed [WIDE_W-1:0] sm;
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] tmp;
        logic signed [W-1:0]      ps;
        logic signed [W-1:0]      vv;
        logic [W-1:0]             qc;
        sm  = smul_fin(mneg, mrsp.prod);
        lo  = ext(r_min) - OVER_W;
        hi  = ext(r_max) + OVER_W;
        tmp = '0;
        ps  = '0;
        vv  = '0;
        qc  = '0;
        n_state     = r_state;
        n_issue     = 1'b0;
        n_p         = r_p;
        n_v         = r_v;
        n_drag      = r_drag;
        n_e         = r_e;
        n_bound     = r_bound;
        n_ob        = r_ob;
        n_hi_done   = r_hi_done;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_x         = r_x;
        n_n         = r_n;
        n_f         = r_f;
        n_idx       = r_idx;
        div_start   = 1'b0;
        load_out    = 1'b0;
        n_out_valid = r_out_valid & ~i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_cmd'(i_command))
                        CMD_RESTART: begin
                            n_p     = r_min;
                            n_v     = '0;
                            n_drag  = 1'b0;
                            n_state = S_FIN;
                        end
                        CMD_RELEASE: begin
                            n_drag = 1'b0;
                            tmp    = ext(r_v);
                            if (tmp > REL_W)  tmp = REL_W;
                            if (tmp < -REL_W) tmp = -REL_W;
                            n_v     = sat_v(tmp);
                            n_state = S_FIN;
                        end
                        CMD_DRAG: begin
                            n_drag = 1'b1;
                            n_p    = sat_v(ext(r_p) + ext(i_delta));
                            if (e_scaled > DRAG_TH) begin
                                div_start = 1'b1;
                                n_neg     = i_delta < 0;
                                n_state   = S_DIV;
                            end else begin
                                n_v     = '0;
                                n_state = S_FIN;
                            end
                        end
                        CMD_TICK: begin
                            n_e = i_elapsed;
                            if (r_drag || i_elapsed == '0) begin
                                n_state = S_FIN;
                            end else if (r_p < r_min || r_p > r_max) begin
                                n_ob    = 1'b1;
                                n_bound = (r_p < r_min) ? r_min : r_max;
                                n_issue = 1'b1;
                                n_state = S_K;
                            end else begin
                                n_ob    = 1'b0;
                                n_issue = 1'b1;
                                n_state = S_X;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    qc = (div_quot >= (QW'(1) << (W - 1))) ? (W'(1) << (W - 1))
                                                           : W'(div_quot);
                    tmp     = $signed(WIDE_W'(qc));
                    n_v     = sat_v(r_neg ? -tmp : tmp);
                    n_state = S_FIN;
                end
            end
            S_K: begin
                if (mrsp.done) begin
                    n_acc   = -sm;
                    n_issue = 1'b1;
                    n_state = S_C;
                end
            end
            S_C: begin
                if (mrsp.done) begin
                    n_acc   = sat_lim(r_acc - sm);
                    n_issue = 1'b1;
                    n_state = S_AD;
                end
            end
            S_AD: begin
                if (mrsp.done) begin
                    n_v     = sat_v(ext(r_v) + rsh_r(sm, 8 + TFB));
                    n_issue = 1'b1;
                    n_state = S_VD;
                end
            end
            S_VD: begin
                if (mrsp.done) begin
                    ps = sat_v(ext(r_p) + rsh_r(sm, TFB));
                    if (r_ob) begin
                        if (ext(ps) < lo) begin
                            n_p       = W'(lo);
                            n_hi_done = 1'b0;
                            n_issue   = 1'b1;
                            n_state   = S_BNC;
                        end else if (ext(ps) > hi) begin
                            n_p       = W'(hi);
                            n_hi_done = 1'b1;
                            n_issue   = 1'b1;
                            n_state   = S_BNC;
                        end else begin
                            n_p     = ps;
                            n_state = S_FIN;
                        end
                    end else begin
                        vv = r_v;
                        if (ps < r_min) begin
                            ps = r_min;
                            if (vv < 0) vv = '0;
                        end
                        if (ps > r_max) begin
                            ps = r_max;
                            if (vv > 0) vv = '0;
                        end
                        if (ext(vv) > -ONE_W && ext(vv) < ONE_W) vv = '0;
                        n_p     = ps;
                        n_v     = vv;
                        n_state = S_FIN;
                    end
                end
            end
            S_BNC: begin
                if (mrsp.done) begin
                    n_v = sat_v(-rsh_r(sm, 16));
                    // the upper limit is still checked after a bounce off the lower one
                    if (!r_hi_done && ext(r_p) > hi) begin
                        n_p       = W'(hi);
                        n_hi_done = 1'b1;
                        n_issue   = 1'b1;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_X: begin
                if (mrsp.done) begin
                    n_x     = mrsp.prod[TFB-8 +: 32];
                    n_issue = 1'b1;
                    n_state = S_Y;
                end
            end
            S_Y: begin
                if (mrsp.done) begin
                    n_n     = mrsp.prod[Y_FRAC +: N_W];
                    n_f     = mrsp.prod[Y_FRAC-1:0];
                    n_issue = 1'b1;
                    n_state = S_I;
                end
            end
            S_I: begin
                if (mrsp.done) begin
                    n_idx   = mrsp.prod[Y_FRAC +: IW];
                    n_state = S_T;
                end
            end
            S_T: begin
                n_issue = 1'b1;
                n_state = S_E;
            end
            S_E: begin
                if (mrsp.done) begin
                    n_v     = sat_v(rsh_r(sm, 30));
                    n_issue = 1'b1;
                    n_state = S_VD;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_p         <= '0;
            r_v         <= '0;
            r_drag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_p         <= n_p;
            r_v         <= n_v;
            r_drag      <= n_drag;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e       <= n_e;
        r_bound   <= n_bound;
        r_ob      <= n_ob;
        r_hi_done <= n_hi_done;
        r_neg     <= n_neg;
        r_acc     <= n_acc;
        r_x       <= n_x;
        r_n       <= n_n;
        r_f       <= n_f;
        r_idx     <= n_idx;
        if (r_state == S_T) begin
            r_expf <= (r_n >= N_W'(EXP_SH_MAX)) ? '0 : (EXP_TAB[r_idx] >> r_n[4:0]);
        end
        if (load_out) begin
            r_out_pos  <= r_p;
            r_out_vel  <= r_v;
            r_out_drag <= r_drag;
            r_out_rest <= out_rest;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_out_pos;
    assign o_velocity  = r_out_vel;
    assign o_dragging  = r_out_drag;
    assign o_resting   = r_out_rest;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:ASH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '0;
            r_max   <= '0;
            r_decay <= DECAY_RST;
            r_stiff <= STIFF_RST;
            r_damp  <= DAMP_RST;
        end else if (cfg_wr) begin
            case (t_reg_idx'(cfg_idx))
                REG_MIN:   r_min   <= pwdata[W-1:0];
                REG_MAX:   r_max   <= pwdata[W-1:0];
                REG_DECAY: r_decay <= pwdata[GAIN_W-1:0];
                REG_STIFF: r_stiff <= pwdata[GAIN_W-1:0];
                REG_DAMP:  r_damp  <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(cfg_idx))
            REG_MIN:   prdata = DATA_W'(r_min);
            REG_MAX:   prdata = DATA_W'(r_max);
            REG_DECAY: prdata = DATA_W'(r_decay);
            REG_STIFF: prdata = DATA_W'(r_stiff);
            REG_DAMP:  prdata = DATA_W'(r_damp);
            default:   prdata = '0;
        endcase
    end

endmodule

### hw/rtl/isp_mul.sv
// isp_mul: iterative unsigned multiplier, one 16-bit digit of operand a per cycle.
// Depends on isp_pkg (widths, request/response structs).
module isp_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  isp_pkg::t_mul_req i_req,
    output isp_pkg::t_mul_rsp o_rsp
);
    import isp_pkg::*;

    localparam int CNT_W = (MUL_DIGITS > 1) ? $clog2(MUL_DIGITS) : 1;
    localparam int EXT_W = MUL_DIGITS * MUL_DIGIT_W;

    logic [MUL_A_W-1:0]             r_a;
    logic [MUL_B_W-1:0]             r_b;
    logic [CNT_W-1:0]               r_cnt;
    logic [MUL_P_W-1:0]             r_acc;
    logic                           r_busy;
    logic                           r_done;
    logic [EXT_W-1:0]               a_ext;
    logic [MUL_DIGIT_W-1:0]         digit;
    logic [MUL_DIGIT_W+MUL_B_W-1:0] part;
    logic [MUL_P_W-1:0]             part_sh;

    assign a_ext   = EXT_W'(r_a);
    assign digit   = a_ext[r_cnt*MUL_DIGIT_W +: MUL_DIGIT_W];
    assign part    = digit * r_b;
    assign part_sh = MUL_P_W'(part) << (r_cnt * MUL_DIGIT_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + part_sh;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

### hw/rtl/isp_div.sv
// isp_div: restoring divider, one quotient bit per cycle, for drag velocity.
// Depends on isp_pkg (elapsed width).
module isp_div #(
    parameter int VALUE_WIDTH    = isp_pkg::VALUE_WIDTH_DEF,
    parameter int TIME_FRAC_BITS = isp_pkg::TIME_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [VALUE_WIDTH-1:0]                i_mag,
    input  logic [isp_pkg::ELAPSED_W-1:0]         i_divisor,
    output logic                                  o_done,
    output logic [VALUE_WIDTH+TIME_FRAC_BITS-1:0] o_quot
);
    import isp_pkg::*;

    localparam int QW    = VALUE_WIDTH + TIME_FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);

    logic [QW-1:0]        r_q;
    logic [ELAPSED_W:0]   r_rem;
    logic [ELAPSED_W-1:0] r_div;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [ELAPSED_W:0]   rem_sh;
    logic [ELAPSED_W:0]   rem_sub;
    logic                 take;

    assign rem_sh  = {r_rem[ELAPSED_W-1:0], r_q[QW-1]};
    assign take    = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {i_mag, {TIME_FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[QW-2:0], take};
            r_rem <= take ? rem_sub : rem_sh;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
